### hdl/bctvf_pkg.sv
// shared types and constants for the bc texture block vertical flip
// no dependencies; imported by every module of the block
package bctvf_pkg;

  localparam int unsigned DIM_W      = 15;
  localparam int unsigned GRID_W     = 14;
  localparam int unsigned POS_W      = 12;
  localparam int unsigned OFFSET_W   = 28;
  localparam int unsigned WORD_W     = 64;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 15;

  typedef enum logic [1:0] {
    FMT_BC1 = 2'd0,
    FMT_BC3 = 2'd1,
    FMT_BC5 = 2'd2,
    FMT_BC7 = 2'd3
  } fmt_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IMAGE_WIDTH  = 2'd0,
    CFG_IMAGE_HEIGHT = 2'd1,
    CFG_BLOCK_FORMAT = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic [DIM_W-1:0] image_width;
    logic [DIM_W-1:0] image_height;
    fmt_t             block_format;
  } cfg_t;

  typedef struct packed {
    logic [POS_W-1:0]    dest_row;
    logic [OFFSET_W-1:0] byte_offset;
    logic                pos_err;
  } addr_res_t;

endpackage

### hdl/bctvf_flip.sv
// block payload flip: reverses bc1 and bc4-style index rows; bc7 as is
// depends on bctvf_pkg
module bctvf_flip import bctvf_pkg::*; (
  input  fmt_t              fmt,
  input  logic [WORD_W-1:0] lo_word,
  input  logic [WORD_W-1:0] hi_word,
  output logic [WORD_W-1:0] flip_lo,
  output logic [WORD_W-1:0] flip_hi
);

  // endpoints kept, one index byte per pixel row
  function automatic logic [WORD_W-1:0] flip_bc1_half(input logic [WORD_W-1:0] w);
    return {w[39:32], w[47:40], w[55:48], w[63:56], w[31:0]};
  endfunction

  // two endpoint bytes kept, four 12-bit index rows reversed
  function automatic logic [WORD_W-1:0] flip_bc4_half(input logic [WORD_W-1:0] w);
    return {w[27:16], w[39:28], w[51:40], w[63:52], w[15:0]};
  endfunction

  always_comb begin
    case (fmt)
      FMT_BC1: begin
        flip_lo = flip_bc1_half(lo_word);
        flip_hi = '0;
      end
      FMT_BC3: begin
        flip_lo = flip_bc4_half(lo_word);
        flip_hi = flip_bc1_half(hi_word);
      end
      FMT_BC5: begin
        flip_lo = flip_bc4_half(lo_word);
        flip_hi = flip_bc4_half(hi_word);
      end
      default: begin
        flip_lo = lo_word;
        flip_hi = hi_word;
      end
    endcase
  end

endmodule

### hdl/bctvf_addr.sv
// destination row, byte offset and range check for one block
// depends on bctvf_pkg
module bctvf_addr import bctvf_pkg::*; #(
  parameter int unsigned MAX_TEXTURE_DIM = 16384
) (
  input  cfg_t             cfg,
  input  logic [POS_W-1:0] src_row,
  input  logic [POS_W-1:0] src_col,
  output addr_res_t        res
);

  localparam logic [16:0] MAX_DIM = 17'(MAX_TEXTURE_DIM);

  logic [DIM_W-1:0]     width_clamp;
  logic [DIM_W-1:0]     height_clamp;
  logic [DIM_W:0]       width_round;
  logic [DIM_W:0]       height_round;
  logic [GRID_W-1:0]    grid_w;
  logic [GRID_W-1:0]    grid_h;
  logic [GRID_W-1:0]    dest_row_full;
  logic [2*GRID_W-1:0]  row_base;
  logic [2*GRID_W:0]    block_idx;
  logic [2*GRID_W+4:0]  offset_full;
  logic                 err;

  // a clamp above the register range never fires, so the cut to DIM_W is safe
  assign width_clamp  = ({2'b0, cfg.image_width} > MAX_DIM) ? MAX_DIM[DIM_W-1:0]
                                                            : cfg.image_width;
  assign height_clamp = ({2'b0, cfg.image_height} > MAX_DIM) ? MAX_DIM[DIM_W-1:0]
                                                             : cfg.image_height;

  // ceil(dim / 4)
  assign width_round  = {1'b0, width_clamp} + (DIM_W+1)'(3);
  assign height_round = {1'b0, height_clamp} + (DIM_W+1)'(3);
  assign grid_w = width_round[DIM_W:2];
  assign grid_h = height_round[DIM_W:2];

  assign err = ({2'b0, src_row} >= grid_h) || ({2'b0, src_col} >= grid_w);

  assign dest_row_full = grid_h - GRID_W'(1) - {2'b0, src_row};
  assign row_base      = dest_row_full * grid_w;
  assign block_idx     = {1'b0, row_base} + (2*GRID_W+1)'(src_col);
  assign offset_full   = (cfg.block_format == FMT_BC1) ? {block_idx, 3'b000, 1'b0} >> 1
                                                       : {block_idx, 4'b0000};

  always_comb begin
    res.pos_err     = err;
    res.dest_row    = err ? '0 : dest_row_full[POS_W-1:0];
    res.byte_offset = err ? '0 : offset_full[OFFSET_W-1:0];
  end

endmodule

### hdl/bc_texture_block_vertical_flip.sv
// top level of the bc texture block vertical flip: config registers and pipeline
// depends on bctvf_pkg, bctvf_flip and bctvf_addr
//
// Flips one BC1/BC3/BC5 block, or passes one BC7 block through unchanged, per
// cycle while out_stall is low. An item is registered on input, flipped and
// placed by one stage of logic, and held in a result register. The input side
// stalls only when a registered item cannot move into a result register that
// is still waiting. Block placement uses the current image_width, image_height
// and block_format; write them only while no item is in flight. Positions
// outside the block grid give position_error with a zero row and offset; the
// flipped block is still returned.
module bc_texture_block_vertical_flip import bctvf_pkg::*; #(
  parameter int unsigned MAX_TEXTURE_DIM = 16384
) (
  input  logic                  clk,
  input  logic                  rst_n,

  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,

  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [WORD_W-1:0]     in_block_low_word,
  input  logic [WORD_W-1:0]     in_block_high_word,
  input  logic [POS_W-1:0]      in_source_block_row,
  input  logic [POS_W-1:0]      in_source_block_col,

  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [WORD_W-1:0]     out_flipped_low_word,
  output logic [WORD_W-1:0]     out_flipped_high_word,
  output logic [POS_W-1:0]      out_dest_block_row,
  output logic [OFFSET_W-1:0]   out_dest_byte_offset,
  output logic                  out_position_error
);

  cfg_t cfg_r;

  logic              s1_valid_r;
  logic [WORD_W-1:0] s1_lo_r;
  logic [WORD_W-1:0] s1_hi_r;
  logic [POS_W-1:0]  s1_row_r;
  logic [POS_W-1:0]  s1_col_r;

  logic                out_valid_r;
  logic [WORD_W-1:0]   out_lo_r;
  logic [WORD_W-1:0]   out_hi_r;
  logic [POS_W-1:0]    out_row_r;
  logic [OFFSET_W-1:0] out_offset_r;
  logic                out_err_r;

  logic [WORD_W-1:0] flip_lo;
  logic [WORD_W-1:0] flip_hi;
  addr_res_t         addr_res;
  logic              s1_advance;
  logic              in_take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.image_width  <= DIM_W'(4);
      cfg_r.image_height <= DIM_W'(4);
      cfg_r.block_format <= FMT_BC1;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_IMAGE_WIDTH:  cfg_r.image_width  <= cfg_wdata[DIM_W-1:0];
        CFG_IMAGE_HEIGHT: cfg_r.image_height <= cfg_wdata[DIM_W-1:0];
        CFG_BLOCK_FORMAT: cfg_r.block_format <= fmt_t'(cfg_wdata[1:0]);
        default: ;
      endcase
    end
  end

  // the result register frees up when empty or when its item is taken
  assign s1_advance = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall   = s1_valid_r && !s1_advance;
  assign in_take    = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_take) begin
      s1_valid_r <= 1'b1;
    end else if (s1_advance) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_lo_r  <= in_block_low_word;
      s1_hi_r  <= in_block_high_word;
      s1_row_r <= in_source_block_row;
      s1_col_r <= in_source_block_col;
    end
  end

  bctvf_flip u_flip (
    .fmt     (cfg_r.block_format),
    .lo_word (s1_lo_r),
    .hi_word (s1_hi_r),
    .flip_lo (flip_lo),
    .flip_hi (flip_hi)
  );

  bctvf_addr #(
    .MAX_TEXTURE_DIM (MAX_TEXTURE_DIM)
  ) u_addr (
    .cfg     (cfg_r),
    .src_row (s1_row_r),
    .src_col (s1_col_r),
    .res     (addr_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_advance) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance) begin
      out_lo_r     <= flip_lo;
      out_hi_r     <= flip_hi;
      out_row_r    <= addr_res.dest_row;
      out_offset_r <= addr_res.byte_offset;
      out_err_r    <= addr_res.pos_err;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_flipped_low_word  = out_lo_r;
  assign out_flipped_high_word = out_hi_r;
  assign out_dest_block_row    = out_row_r;
  assign out_dest_byte_offset  = out_offset_r;
  assign out_position_error    = out_err_r;

  // the input side only backs up behind a held item
  a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid_r && out_valid_r))
    else $error("input stalled with no item held");

  a_take_fills_stage: assert property (@(posedge clk) disable iff (!rst_n)
    in_take |=> s1_valid_r)
    else $error("accepted item lost from input register");

  a_err_zeroes_place: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_err_r) |-> (out_row_r == '0 && out_offset_r == '0))
    else $error("out-of-grid block carries a row or offset");

  a_offset_aligned: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_offset_r[2:0] == 3'b000))
    else $error("byte offset not block aligned");

endmodule

### bench/tb.sv
// testbench for bc_texture_block_vertical_flip: directed table, then random phases,
// every result checked against typed-in values or the flip and placement predictor
// depends on bctvf_pkg and the bc_texture_block_vertical_flip rtl
module tb import bctvf_pkg::*; ();

  localparam int unsigned MAX_DIM = 16384;
  localparam int unsigned QUIET_LIMIT = 2000;
  localparam int unsigned DRAIN_CYCLES = 6;
  localparam int unsigned NUM_DIRECTED = 22;
  localparam int unsigned NUM_PHASES = 8;
  localparam int unsigned ITEMS_PER_PHASE = 195;
  // an index past the register list, writes to it must be dropped
  localparam logic [CFG_IDX_W-1:0] CFG_NONE = 2'd3;
  localparam logic [WORD_W-1:0] ONES = '1;
  localparam logic [WORD_W-1:0] SAMPLE = 64'h0123456789abcdef;
  localparam logic [WORD_W-1:0] SAMPLE_REV = 64'hfedcba9876543210;

  typedef struct packed {
    logic [WORD_W-1:0]   lo;
    logic [WORD_W-1:0]   hi;
    logic [POS_W-1:0]    row;
    logic [OFFSET_W-1:0] off;
    logic                err;
  } flip_res_t;

  typedef struct packed {
    logic [DIM_W-1:0] w;
    logic [DIM_W-1:0] h;
    fmt_t             fmt;
    logic [WORD_W-1:0] lo;
    logic [WORD_W-1:0] hi;
    logic [POS_W-1:0] row;
    logic [POS_W-1:0] col;
    logic             typed;
    flip_res_t        want;
  } dir_row_t;

  localparam flip_res_t UNTYPED = '0;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [WORD_W-1:0]     in_block_low_word = '0;
  logic [WORD_W-1:0]     in_block_high_word = '0;
  logic [POS_W-1:0]      in_source_block_row = '0;
  logic [POS_W-1:0]      in_source_block_col = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [WORD_W-1:0]     out_flipped_low_word;
  logic [WORD_W-1:0]     out_flipped_high_word;
  logic [POS_W-1:0]      out_dest_block_row;
  logic [OFFSET_W-1:0]   out_dest_byte_offset;
  logic                  out_position_error;

  // register mirror
  logic [DIM_W-1:0] img_w = 15'd4;
  logic [DIM_W-1:0] img_h = 15'd4;
  fmt_t             img_fmt = FMT_BC1;

  flip_res_t   pending_flips [$];
  int unsigned mismatches = 0;
  int unsigned quiet_cycles = 0;
  int unsigned idle_pct = 0;
  int unsigned stall_pct = 0;
  dir_row_t    directed [NUM_DIRECTED];

  bc_texture_block_vertical_flip #(
    .MAX_TEXTURE_DIM(MAX_DIM)
  ) uut (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_block_low_word(in_block_low_word),
    .in_block_high_word(in_block_high_word),
    .in_source_block_row(in_source_block_row),
    .in_source_block_col(in_source_block_col),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_flipped_low_word(out_flipped_low_word),
    .out_flipped_high_word(out_flipped_high_word),
    .out_dest_block_row(out_dest_block_row),
    .out_dest_byte_offset(out_dest_byte_offset),
    .out_position_error(out_position_error)
  );

  always #5 clk = ~clk;

  // endpoints kept, the four index row bytes reversed
  function automatic logic [WORD_W-1:0] bc1_half_flip(logic [WORD_W-1:0] w);
    return {w[39:32], w[47:40], w[55:48], w[63:56], w[31:0]};
  endfunction

  // endpoints kept, the four 12-bit index rows reversed
  function automatic logic [WORD_W-1:0] bc4_half_flip(logic [WORD_W-1:0] w);
    return {w[27:16], w[39:28], w[51:40], w[63:52], w[15:0]};
  endfunction

  function automatic int unsigned grid_dim(logic [DIM_W-1:0] d);
    int unsigned v;
    v = (d > MAX_DIM) ? MAX_DIM : d;
    return (v + 3) / 4;
  endfunction

  function automatic flip_res_t predict_flip(logic [WORD_W-1:0] lo, logic [WORD_W-1:0] hi,
                                             logic [POS_W-1:0] row, logic [POS_W-1:0] col);
    flip_res_t r;
    longint unsigned gw;
    longint unsigned gh;
    longint unsigned dest;
    longint unsigned off;
    longint unsigned blk_bytes;
    gw = grid_dim(img_w);
    gh = grid_dim(img_h);
    blk_bytes = (img_fmt == FMT_BC1) ? 8 : 16;
    case (img_fmt)
      FMT_BC1: begin
        r.lo = bc1_half_flip(lo);
        r.hi = '0;
      end
      FMT_BC3: begin
        r.lo = bc4_half_flip(lo);
        r.hi = bc1_half_flip(hi);
      end
      FMT_BC5: begin
        r.lo = bc4_half_flip(lo);
        r.hi = bc4_half_flip(hi);
      end
      default: begin
        r.lo = lo;
        r.hi = hi;
      end
    endcase
    r.err = (row >= gh) || (col >= gw);
    r.row = '0;
    r.off = '0;
    if (!r.err) begin
      dest = gh - 1 - row;
      off = (dest * gw + col) * blk_bytes;
      r.row = dest[POS_W-1:0];
      r.off = off[OFFSET_W-1:0];
    end
    return r;
  endfunction

  function automatic void mirror_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    case (idx)
      CFG_IMAGE_WIDTH:  img_w = data;
      CFG_IMAGE_HEIGHT: img_h = data;
      CFG_BLOCK_FORMAT: img_fmt = fmt_t'(data[1:0]);
      default: ;
    endcase
  endfunction

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    mirror_write(idx, data);
  endtask

  // only called with nothing in flight
  task automatic program_regs(logic [DIM_W-1:0] w, logic [DIM_W-1:0] h, fmt_t fmt, bit poke);
    cfg_we <= 1'b1;
    write_reg(CFG_IMAGE_WIDTH, w);
    write_reg(CFG_IMAGE_HEIGHT, h);
    write_reg(CFG_BLOCK_FORMAT, {{(CFG_DATA_W-2){1'b0}}, fmt});
    if (poke) begin
      write_reg(CFG_NONE, CFG_DATA_W'($urandom));
    end
    cfg_we <= 1'b0;
  endtask

  task automatic wait_drain();
    in_valid <= 1'b0;
    while (pending_flips.size() != 0) @(posedge clk);
  endtask

  task automatic send_item(logic [WORD_W-1:0] lo, logic [WORD_W-1:0] hi,
                           logic [POS_W-1:0] row, logic [POS_W-1:0] col, flip_res_t want);
    while (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_block_low_word <= lo;
    in_block_high_word <= hi;
    in_source_block_row <= row;
    in_source_block_col <= col;
    pending_flips.push_back(want);
    do @(posedge clk); while (in_stall);
  endtask

  function automatic logic [WORD_W-1:0] rand_word();
    case ($urandom_range(0, 15))
      0: return '0;
      1: return ONES;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic logic [DIM_W-1:0] rand_dim();
    case ($urandom_range(0, 19))
      0: return 15'd0;
      1, 2: return 15'd1;
      3: return 15'd4;
      4: return 15'd16384;
      5: return 15'h7fff;
      6: return DIM_W'($urandom_range(16385, 32767));
      7, 8, 9, 10: return DIM_W'($urandom_range(1, 64));
      default: return DIM_W'($urandom_range(1, 16384));
    endcase
  endfunction

  // mostly inside the grid, with its last row or column hit often
  function automatic logic [POS_W-1:0] rand_pos(int unsigned span);
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (span != 0 && pick < 10) return POS_W'(span - 1);
    if (span != 0 && pick < 85) return POS_W'($urandom_range(0, span - 1));
    return POS_W'($urandom_range(0, 4095));
  endfunction

  task automatic check_field(string name, logic [WORD_W-1:0] want, logic [WORD_W-1:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    out_stall <= (stall_pct != 0 && $urandom_range(0, 99) < stall_pct);
  end

  always @(posedge clk) begin
    flip_res_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_flips.size() == 0) begin
        $error("result item with no expectation waiting");
        mismatches++;
      end else begin
        want = pending_flips.pop_front();
        check_field("flipped_low_word", want.lo, out_flipped_low_word);
        check_field("flipped_high_word", want.hi, out_flipped_high_word);
        check_field("dest_block_row", want.row, out_dest_block_row);
        check_field("dest_byte_offset", want.off, out_dest_byte_offset);
        check_field("position_error", want.err, out_position_error);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("tb: FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    dir_row_t d;
    flip_res_t want;
    logic [WORD_W-1:0] lo;
    logic [WORD_W-1:0] hi;
    directed = '{
      // reset setting: 4x4 pixels, one bc1 block
      '{15'd4, 15'd4, FMT_BC1, SAMPLE, ONES, 12'd0, 12'd0, 1'b1,
        '{64'h6745230189abcdef, 64'd0, 12'd0, 28'd0, 1'b0}},
      '{15'd4, 15'd4, FMT_BC1, ONES, 64'd0, 12'd0, 12'd0, 1'b1,
        '{ONES, 64'd0, 12'd0, 28'd0, 1'b0}},
      '{15'd4, 15'd4, FMT_BC1, 64'd0, 64'd0, 12'd1, 12'd0, 1'b1,
        '{64'd0, 64'd0, 12'd0, 28'd0, 1'b1}},
      '{15'd4, 15'd4, FMT_BC1, 64'd0, 64'd0, 12'd0, 12'd4095, 1'b1,
        '{64'd0, 64'd0, 12'd0, 28'd0, 1'b1}},
      '{15'd4, 15'd4, FMT_BC1, ONES, ONES, 12'd4095, 12'd4095, 1'b1,
        '{ONES, 64'd0, 12'd0, 28'd0, 1'b1}},
      // largest grid, pass-through
      '{15'd16384, 15'd16384, FMT_BC7, SAMPLE, SAMPLE_REV, 12'd0, 12'd0, 1'b1,
        '{SAMPLE, SAMPLE_REV, 12'd4095, 28'h0fff0000, 1'b0}},
      '{15'd16384, 15'd16384, FMT_BC7, ONES, ONES, 12'd4095, 12'd4095, 1'b1,
        '{ONES, ONES, 12'd0, 28'h000fff0, 1'b0}},
      '{15'd16384, 15'd16384, FMT_BC7, 64'd0, SAMPLE, 12'd2048, 12'd1, 1'b0, UNTYPED},
      // widest register value saturates to the largest grid
      '{15'h7fff, 15'h7fff, FMT_BC5, SAMPLE, ONES, 12'd0, 12'd0, 1'b0, UNTYPED},
      '{15'h7fff, 15'h7fff, FMT_BC5, 64'haaaa5555cccc3333, SAMPLE_REV, 12'd4095, 12'd0,
        1'b0, UNTYPED},
      '{15'h7fff, 15'h7fff, FMT_BC5, 64'd0, 64'd0, 12'd4095, 12'd4095, 1'b1,
        '{64'd0, 64'd0, 12'd0, 28'h000fff0, 1'b0}},
      // empty grid, every position flagged; then a one-block 1x1 grid
      '{15'd0, 15'd4, FMT_BC3, SAMPLE, SAMPLE, 12'd0, 12'd0, 1'b0, UNTYPED},
      '{15'd0, 15'd4, FMT_BC3, ONES, ONES, 12'd4095, 12'd4095, 1'b1,
        '{ONES, ONES, 12'd0, 28'd0, 1'b1}},
      '{15'd4, 15'd0, FMT_BC1, 64'd0, ONES, 12'd0, 12'd0, 1'b1,
        '{64'd0, 64'd0, 12'd0, 28'd0, 1'b1}},
      '{15'd1, 15'd1, FMT_BC3, SAMPLE, SAMPLE_REV, 12'd0, 12'd0, 1'b0, UNTYPED},
      '{15'd1, 15'd1, FMT_BC3, SAMPLE_REV, SAMPLE, 12'd0, 12'd1, 1'b0, UNTYPED},
      // partial blocks at the right and bottom edges
      '{15'd5, 15'd9, FMT_BC5, SAMPLE, SAMPLE_REV, 12'd0, 12'd1, 1'b0, UNTYPED},
      '{15'd5, 15'd9, FMT_BC5, SAMPLE_REV, SAMPLE, 12'd2, 12'd0, 1'b0, UNTYPED},
      '{15'd5, 15'd9, FMT_BC5, ONES, SAMPLE, 12'd3, 12'd0, 1'b0, UNTYPED},
      '{15'd5, 15'd9, FMT_BC5, SAMPLE, ONES, 12'd1, 12'd2, 1'b0, UNTYPED},
      '{15'd16383, 15'd3, FMT_BC1, SAMPLE, SAMPLE, 12'd0, 12'd4095, 1'b0, UNTYPED},
      '{15'd16385, 15'd16385, FMT_BC3, SAMPLE_REV, ONES, 12'd4095, 12'd17, 1'b0, UNTYPED}
    };

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed[i]) begin
      d = directed[i];
      if (d.w != img_w || d.h != img_h || d.fmt != img_fmt) begin
        wait_drain();
        program_regs(d.w, d.h, d.fmt, $urandom_range(0, 1));
      end
      want = d.typed ? d.want : predict_flip(d.lo, d.hi, d.row, d.col);
      send_item(d.lo, d.hi, d.row, d.col, want);
    end

    for (int p = 0; p < NUM_PHASES; p++) begin
      wait_drain();
      case (p % 4)
        0: begin
          idle_pct = 0;
          stall_pct = 0;
        end
        1: begin
          idle_pct = 84;
          stall_pct = 0;
        end
        2: begin
          idle_pct = 0;
          stall_pct = 84;
        end
        default: begin
          idle_pct = 25;
          stall_pct = 25;
        end
      endcase
      program_regs(rand_dim(), rand_dim(), fmt_t'(p >> 1), $urandom_range(0, 1));
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        logic [POS_W-1:0] row;
        logic [POS_W-1:0] col;
        lo = rand_word();
        hi = rand_word();
        row = rand_pos(grid_dim(img_h));
        col = rand_pos(grid_dim(img_w));
        send_item(lo, hi, row, col, predict_flip(lo, hi, row, col));
      end
    end

    wait_drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_flips.size() == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule

### files.f
hdl/bctvf_pkg.sv
hdl/bctvf_flip.sv
hdl/bctvf_addr.sv
hdl/bc_texture_block_vertical_flip.sv
bench/tb.sv
